@@ sv/touch_five_point_calibrator_assert.svh @@
// Assertion macros for the touch calibrator checker.
`ifndef TOUCH_FIVE_POINT_CALIBRATOR_ASSERT_SVH
`define TOUCH_FIVE_POINT_CALIBRATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TFPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfpc check failed");

// next-cycle implication, disabled in reset
`define TFPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfpc check failed");

`endif

@@ sv/tfpc_pkg.sv @@
`timescale 1ns / 1ps
package tfpc_pkg;

  localparam int NUM_POINTS_DEF = 5;
  localparam int COORD_W        = 12;
  localparam int BOUND_W        = 16;

  localparam logic [11:0] EDGE_LO = 12'd50;
  localparam logic [11:0] EDGE_HI = 12'd4060;

  localparam logic [11:0] WIDTH_RST  = 12'd320;
  localparam logic [11:0] HEIGHT_RST = 12'd240;

  // n/280 = (n>>3)/35 and n/200 = (n>>3)/25, each as a multiply by a
  // reciprocal scaled by 2^27; exact for n below 2^24
  localparam logic [22:0] RCP_X  = 23'd3834793;
  localparam logic [22:0] RCP_Y  = 23'd5368710;
  localparam int          RCP_SH = 27;
  localparam logic signed [12:0] MARGIN = 13'sd20;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  localparam logic [1:0] REG_SWAP   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [2:0] LAST_CHECK = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT,
    S_CHK_RD, S_CHK_A1, S_CHK_A2, S_CHK_B1, S_CHK_B2, S_CHK_CMP,
    S_BND_RD, S_BND_D1, S_BND_D2, S_MUL, S_DIV, S_RCP, S_ACC
  } state_t;

  typedef struct packed {
    logic [2:0] ia;
    logic [2:0] ja;
    logic [2:0] ib;
    logic [2:0] jb;
    logic       span;
    logic       axis_y;
  } chk_t;

  // Point order: 0 top left, 1 top right, 2 bottom left, 3 bottom right, 4 center.
  function automatic chk_t chk_sel(input logic [2:0] c);
    chk_t r;
    r = '0;
    case (c)
      3'd0: r = '{3'd0, 3'd1, 3'd2, 3'd3, 1'b0, 1'b0};
      3'd1: r = '{3'd0, 3'd2, 3'd1, 3'd3, 1'b0, 1'b0};
      3'd2: r = '{3'd1, 3'd2, 3'd0, 3'd3, 1'b0, 1'b0};
      3'd3: r = '{3'd4, 3'd0, 3'd4, 3'd3, 1'b1, 1'b0};
      3'd4: r = '{3'd4, 3'd0, 3'd4, 3'd3, 1'b1, 1'b1};
      3'd5: r = '{3'd4, 3'd1, 3'd4, 3'd2, 1'b1, 1'b0};
      3'd6: r = '{3'd4, 3'd1, 3'd4, 3'd2, 1'b1, 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/touch_five_point_calibrator.sv @@
`timescale 1ns / 1ps
// An ignored or stored sample is accepted and then emitted. The fifth sample is
// accepted, runs up to 7 checks, then bound setup and 4 bounds, each using a
// reciprocal multiply for the constant divide, and is then emitted.
// One sample in flight; output register lets the next sample enter while a
// result waits. Reset (sync, active high) clears the point count and
// registers to defaults; the point memory is not cleared.
module touch_five_point_calibrator #(
  parameter int NUM_POINTS = tfpc_pkg::NUM_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tfpc_pkg::COORD_W-1:0]        raw_x,
  input  logic [tfpc_pkg::COORD_W-1:0]        raw_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic [2:0]                          next_target,
  output logic signed [tfpc_pkg::BOUND_W-1:0] bound_x_min,
  output logic signed [tfpc_pkg::BOUND_W-1:0] bound_x_max,
  output logic signed [tfpc_pkg::BOUND_W-1:0] bound_y_min,
  output logic signed [tfpc_pkg::BOUND_W-1:0] bound_y_max,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_idx,
  input  logic [tfpc_pkg::COORD_W-1:0]        cfg_wdata
);
  import tfpc_pkg::*;

  localparam int AW       = $clog2(NUM_POINTS);

  state_t state, state_next;

  logic        swap_axes;
  logic [11:0] screen_width, screen_height;
  logic [AW-1:0] cnt;

  logic [23:0] mem [NUM_POINTS];
  logic [23:0] rd_a, rd_b;
  logic          rd_en;
  logic [AW-1:0] addr_a, addr_b;

  logic [2:0]  chk;
  chk_t        cs;
  logic [24:0] acc_a, acc_b;
  logic [11:0] dyreg;
  logic [11:0] ddx, ddy, span_v;
  logic [23:0] sq_x, sq_y;
  logic [27:0] five_a, three_b, two_a;
  logic        pass;

  logic signed [12:0] dxr, dyr, dsel, fsel;
  logic [11:0] x0, y0;
  logic [1:0]  job;
  logic signed [25:0] prod;
  logic        neg;
  logic [23:0] mag;
  logic [22:0] recip;
  logic [43:0] rcp_prod;
  logic [16:0] quo;
  logic signed [17:0] q;
  logic signed [18:0] val;
  logic signed [15:0] sat;

  logic [1:0]  res_status;
  logic [2:0]  res_target;
  logic signed [15:0] res_xmin, res_xmax, res_ymin, res_ymax;

  logic accept, reject, fifth;
  logic [11:0] sx, sy;

  assign accept = in_valid && in_ready;
  assign reject = raw_x <= EDGE_LO || raw_y <= EDGE_LO ||
                  raw_x >= EDGE_HI || raw_y >= EDGE_HI;
  assign fifth  = cnt == AW'(NUM_POINTS - 1);
  assign sx     = swap_axes ? raw_y : raw_x;
  assign sy     = swap_axes ? raw_x : raw_y;

  assign cs = chk_sel(chk);

  always_comb begin
    ddx = (rd_a[11:0] > rd_b[11:0]) ? rd_a[11:0] - rd_b[11:0] : rd_b[11:0] - rd_a[11:0];
    ddy = (rd_a[23:12] > rd_b[23:12]) ? rd_a[23:12] - rd_b[23:12]
                                      : rd_b[23:12] - rd_a[23:12];
    span_v = cs.axis_y ? ddy : ddx;
    sq_x = ddx * ddx;
    sq_y = dyreg * dyreg;
    five_a  = {acc_a, 2'b00} + 28'(acc_a);
    three_b = {2'b00, acc_b, 1'b0} + 28'(acc_b);
    two_a   = {2'b00, acc_a, 1'b0};
    pass = (cs.span || (acc_a != '0 && acc_b != '0)) &&
           five_a >= three_b && two_a <= three_b;
  end

  // bound arithmetic
  always_comb begin
    dsel = job[1] ? dyr : dxr;
    if (!job[0]) fsel = MARGIN;
    else if (!job[1]) fsel = $signed({1'b0, screen_width}) - MARGIN;
    else fsel = $signed({1'b0, screen_height}) - MARGIN;
    recip    = job[1] ? RCP_Y : RCP_X;
    rcp_prod = 44'(mag[23:3]) * 44'(recip);
    q   = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    val = job[1] ? $signed({7'd0, y0}) : $signed({7'd0, x0});
    val = job[0] ? val + 19'(q) : val - 19'(q);
    if (val > 19'sd32767) sat = 16'sh7fff;
    else if (val < -19'sd32768) sat = 16'sh8000;
    else sat = val[15:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = (!reject && fifth) ? S_CHK_RD : S_EMIT;
      S_EMIT:    if (!out_valid || out_ready) state_next = S_IDLE;
      S_CHK_RD:  state_next = S_CHK_A1;
      S_CHK_A1:  state_next = S_CHK_A2;
      S_CHK_A2:  state_next = S_CHK_B1;
      S_CHK_B1:  state_next = S_CHK_B2;
      S_CHK_B2:  state_next = S_CHK_CMP;
      S_CHK_CMP: begin
        if (!pass) state_next = S_EMIT;
        else if (chk == LAST_CHECK) state_next = S_BND_RD;
        else state_next = S_CHK_RD;
      end
      S_BND_RD:  state_next = S_BND_D1;
      S_BND_D1:  state_next = S_BND_D2;
      S_BND_D2:  state_next = S_MUL;
      S_MUL:     state_next = S_DIV;
      S_DIV:     state_next = S_RCP;
      S_RCP:     state_next = S_ACC;
      S_ACC:     state_next = (job == 2'd3) ? S_EMIT : S_MUL;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    addr_a   = '0;
    addr_b   = '0;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_CHK_RD: begin
        rd_en = 1'b1; addr_a = AW'(cs.ia); addr_b = AW'(cs.ja);
      end
      S_CHK_A2: begin
        rd_en = 1'b1; addr_a = AW'(cs.ib); addr_b = AW'(cs.jb);
      end
      S_BND_RD: begin
        rd_en = 1'b1; addr_a = AW'(0); addr_b = AW'(1);
      end
      S_BND_D1: begin
        rd_en = 1'b1; addr_a = AW'(0); addr_b = AW'(2);
      end
      default: ;
    endcase
  end

  // point memory
  always_ff @(posedge clk) begin
    if (accept && !reject) mem[cnt] <= {sy, sx};
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      swap_axes     <= 1'b0;
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SWAP:   swap_axes     <= cfg_wdata[0];
          REG_WIDTH:  screen_width  <= cfg_wdata;
          REG_HEIGHT: screen_height <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && !reject) cnt <= fifth ? '0 : cnt + AW'(1);
      if (state == S_EMIT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        chk        <= '0;
        res_xmin   <= '0;
        res_xmax   <= '0;
        res_ymin   <= '0;
        res_ymax   <= '0;
        if (reject) begin
          res_status <= ST_IGNORED;
          res_target <= 3'(cnt);
        end else begin
          res_status <= ST_STORED;
          res_target <= 3'(cnt) + 3'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          status      <= res_status;
          next_target <= res_target;
          bound_x_min <= res_xmin;
          bound_x_max <= res_xmax;
          bound_y_min <= res_ymin;
          bound_y_max <= res_ymax;
        end
      end
      S_CHK_A1: begin
        acc_a <= cs.span ? 25'(span_v) : 25'(sq_x);
        dyreg <= ddy;
      end
      S_CHK_A2: if (!cs.span) acc_a <= acc_a + 25'(sq_y);
      S_CHK_B1: begin
        acc_b <= cs.span ? 25'(span_v) : 25'(sq_x);
        dyreg <= ddy;
      end
      S_CHK_B2: if (!cs.span) acc_b <= acc_b + 25'(sq_y);
      S_CHK_CMP: begin
        chk <= chk + 3'd1;
        if (!pass) begin
          res_status <= ST_FAILED;
          res_target <= '0;
        end
      end
      S_BND_D1: begin
        x0  <= rd_a[11:0];
        dxr <= $signed({1'b0, rd_b[11:0]}) - $signed({1'b0, rd_a[11:0]});
      end
      S_BND_D2: begin
        y0  <= rd_a[23:12];
        dyr <= $signed({1'b0, rd_b[23:12]}) - $signed({1'b0, rd_a[23:12]});
        job <= '0;
      end
      S_MUL: prod <= dsel * fsel;
      S_DIV: begin
        // sign and magnitude, so the quotient truncates toward zero
        neg <= prod[25];
        mag <= prod[25] ? 24'(-prod) : 24'(prod);
      end
      S_RCP: quo <= rcp_prod[RCP_SH+16:RCP_SH];
      S_ACC: begin
        unique case (job)
          2'd0: res_xmin <= sat;
          2'd1: res_xmax <= sat;
          2'd2: res_ymin <= sat;
          2'd3: res_ymax <= sat;
          default: ;
        endcase
        job        <= job + 2'd1;
        res_status <= ST_DONE;
        res_target <= '0;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/tfpc_checker.sv @@
`timescale 1ns / 1ps
`include "touch_five_point_calibrator_assert.svh"
module tfpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [2:0]        next_target,
  input logic signed [15:0] bound_x_min,
  input logic signed [15:0] bound_x_max,
  input logic signed [15:0] bound_y_min,
  input logic signed [15:0] bound_y_max
);
  import tfpc_pkg::*;

  logic bounds_zero;
  assign bounds_zero = bound_x_min == 0 && bound_x_max == 0 &&
                       bound_y_min == 0 && bound_y_max == 0;

  // bounds only carry data on a done beat
  `TFPC_ASSERT_IMP(a_bounds_zero, out_valid && status != ST_DONE, bounds_zero)
  // restart and completion point back at the first target
  `TFPC_ASSERT_IMP(a_restart_target, out_valid && (status == ST_FAILED || status == ST_DONE), next_target == 3'd0)
  `TFPC_ASSERT_IMP(a_target_range, out_valid, next_target <= 3'd4)
  `TFPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(next_target))

endmodule

bind touch_five_point_calibrator tfpc_checker u_tfpc_checker (.*);

@@ tb/tb_touch_five_point_calibrator.sv @@
`timescale 1ns / 1ps
module tb_touch_five_point_calibrator;
  import tfpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [1:0]         status;
    logic [2:0]         next_target;
    logic signed [15:0] x_min;
    logic signed [15:0] x_max;
    logic signed [15:0] y_min;
    logic signed [15:0] y_max;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] raw_x = '0;
  logic [11:0] raw_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [2:0] next_target;
  logic signed [15:0] bound_x_min, bound_x_max, bound_y_min, bound_y_max;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [11:0] cfg_wdata = '0;

  // shadow of the block's registers and point memory
  logic        cal_swap;
  logic [11:0] cal_width, cal_height;
  logic [11:0] pt_x [5];
  logic [11:0] pt_y [5];
  int          pt_count;

  cal_result_t pending_results[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int done_seen = 0;
  int failed_seen = 0;
  int ignored_seen = 0;
  int idle_cycles = 0;
  int out_wait = 0;
  bit out_stall_off = 1'b0;

  touch_five_point_calibrator i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint adiff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit ratio_within(longint a, longint b);
    return !(5 * a < 3 * b) && !(2 * a > 3 * b);
  endfunction

  function automatic longint sq_dist(int i, int j);
    longint dx, dy;
    dx = adiff(pt_x[i], pt_x[j]);
    dy = adiff(pt_y[i], pt_y[j]);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit side_pair_ok(int i, int j, int k, int l);
    longint a, b;
    a = sq_dist(i, j);
    b = sq_dist(k, l);
    return a != 0 && b != 0 && ratio_within(a, b);
  endfunction

  function automatic bit geometry_ok();
    if (!side_pair_ok(0, 1, 2, 3)) return 1'b0;
    if (!side_pair_ok(0, 2, 1, 3)) return 1'b0;
    if (!side_pair_ok(1, 2, 0, 3)) return 1'b0;
    if (!ratio_within(adiff(pt_x[4], pt_x[0]), adiff(pt_x[4], pt_x[3]))) return 1'b0;
    if (!ratio_within(adiff(pt_y[4], pt_y[0]), adiff(pt_y[4], pt_y[3]))) return 1'b0;
    if (!ratio_within(adiff(pt_x[4], pt_x[1]), adiff(pt_x[4], pt_x[2]))) return 1'b0;
    if (!ratio_within(adiff(pt_y[4], pt_y[1]), adiff(pt_y[4], pt_y[2]))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // SV integer division truncates toward zero, as needed
  function automatic cal_result_t predict_touch(logic [11:0] rx, logic [11:0] ry);
    cal_result_t r;
    logic [11:0] x, y;
    longint dx, dy, w, h;
    r = '{ST_IGNORED, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    if (pt_count >= 5) pt_count = 0;
    if (rx <= EDGE_LO || ry <= EDGE_LO || rx >= EDGE_HI || ry >= EDGE_HI) begin
      r.next_target = pt_count[2:0];
      return r;
    end
    x = cal_swap ? ry : rx;
    y = cal_swap ? rx : ry;
    pt_x[pt_count] = x;
    pt_y[pt_count] = y;
    pt_count++;
    if (pt_count < 5) begin
      r.status = ST_STORED;
      r.next_target = pt_count[2:0];
      return r;
    end
    pt_count = 0;
    if (!geometry_ok()) begin
      r.status = ST_FAILED;
      return r;
    end
    w = cal_width;
    h = cal_height;
    dx = longint'(pt_x[1]) - longint'(pt_x[0]);
    dy = longint'(pt_y[2]) - longint'(pt_y[0]);
    r.status = ST_DONE;
    r.x_min = clamp16(longint'(pt_x[0]) - dx * 20 / 280);
    r.x_max = clamp16(longint'(pt_x[0]) + dx * (w - 20) / 280);
    r.y_min = clamp16(longint'(pt_y[0]) - dy * 20 / 200);
    r.y_max = clamp16(longint'(pt_y[0]) + dy * (h - 20) / 200);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %0d want %0d", what, beats_out, got, want);
    errors++;
  endtask

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // valid stays up between back-to-back beats; it drops only for a gap
  task automatic send_touch(logic [11:0] rx, logic [11:0] ry);
    int gap;
    gap = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      wait_cycles(gap);
    end
    in_valid <= 1'b1;
    raw_x <= rx;
    raw_y <= ry;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_touch(rx, ry));
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles(200); // the fifth point runs long after its beat
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SWAP:   cal_swap = val[0];
      REG_WIDTH:  cal_width = val;
      REG_HEIGHT: cal_height = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [11:0] jitter(int base, int amt);
    int v;
    v = base + $urandom_range(0, 2 * amt) - amt;
    if (v < 51) v = 51;
    if (v > 4059) v = 4059;
    return v[11:0];
  endfunction

  // five-point pass: four corners then the center, each with random jitter
  task automatic send_square(int x0, int y0, int xs, int ys, int jit);
    send_touch(jitter(x0, jit), jitter(y0, jit));
    send_touch(jitter(x0 + xs, jit), jitter(y0, jit));
    send_touch(jitter(x0, jit), jitter(y0 + ys, jit));
    send_touch(jitter(x0 + xs, jit), jitter(y0 + ys, jit));
    send_touch(jitter(x0 + xs / 2, jit), jitter(y0 + ys / 2, jit));
  endtask

  task automatic test_directed();
    send_touch(12'd0, 12'd2000);
    send_touch(12'd4095, 12'd2000);
    send_touch(12'd2000, 12'd50);
    send_touch(12'd2000, 12'd4060);
    send_touch(12'd51, 12'd4059);
    // clean square, sent after one stored point, so it spans two five-point sets
    send_square(400, 400, 3000, 3000, 0);
    // all points identical: zero distances fail
    repeat (5) send_touch(12'd1000, 12'd1000);
    // aspect too skewed
    send_square(100, 100, 3900, 400, 0);
    // center on a corner
    send_touch(12'd500, 12'd500);
    send_touch(12'd3500, 12'd500);
    send_touch(12'd500, 12'd3500);
    send_touch(12'd3500, 12'd3500);
    send_touch(12'd500, 12'd500);
  endtask

  task automatic test_settings();
    drain();
    write_reg(REG_SWAP, 12'd1);
    write_reg(REG_WIDTH, 12'd4095);
    write_reg(REG_HEIGHT, 12'd4095);
    send_square(3900, 3900, -3800, -3800, 0);
    send_square(60, 60, 3990, 3990, 0);
    drain();
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd19);
    send_square(2000, 2000, -1900, 1900, 0);
    drain();
    write_reg(REG_SWAP, 12'd0);
    write_reg(REG_WIDTH, 12'd40);
    write_reg(REG_HEIGHT, 12'd40);
    send_square(1000, 3000, 2000, -2000, 20);
  endtask

  task automatic test_random();
    for (int n = 0; n < 70; n++) begin
      if (n % 20 == 19) begin
        drain();
        write_reg(REG_SWAP, 12'($urandom_range(0, 1)));
        write_reg(REG_WIDTH, 12'($urandom_range(0, 4095)));
        write_reg(REG_HEIGHT, 12'($urandom_range(0, 4095)));
      end
      if ($urandom_range(0, 3) != 0)
        send_square($urandom_range(51, 2000), $urandom_range(51, 2000),
                    $urandom_range(100, 2000), $urandom_range(100, 2000),
                    $urandom_range(0, 150));
      else
        send_touch(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    end
    // full-range noise
    repeat (30) send_touch(12'($urandom), 12'($urandom));
    out_stall_off = 1'b1;
    repeat (10) send_square(300, 300, 2500, 2500, 40);
  endtask

  // receiver draws a wait for every result beat
  always @(posedge clk) begin
    int next_wait;
    if (!rst) begin
      if (out_valid && out_ready) begin
        next_wait = out_stall_off ? 0 : $urandom_range(0, 11);
        out_wait <= next_wait;
        out_ready <= (next_wait == 0);
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ready <= (out_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cal_result_t want;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $display("unexpected result beat %0d", beats_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status != want.status) report_mismatch("status", status, want.status);
        if (next_target != want.next_target)
          report_mismatch("next_target", next_target, want.next_target);
        if (bound_x_min != want.x_min) report_mismatch("x_min", bound_x_min, want.x_min);
        if (bound_x_max != want.x_max) report_mismatch("x_max", bound_x_max, want.x_max);
        if (bound_y_min != want.y_min) report_mismatch("y_min", bound_y_min, want.y_min);
        if (bound_y_max != want.y_max) report_mismatch("y_max", bound_y_max, want.y_max);
        case (want.status)
          ST_DONE:    done_seen++;
          ST_FAILED:  failed_seen++;
          ST_IGNORED: ignored_seen++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cal_swap = 1'b0;
    cal_width = WIDTH_RST;
    cal_height = HEIGHT_RST;
    pt_count = 0;
    wait_cycles(7);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_random();
    drain();
    $display("covered %0d touch beats, %0d results: %0d done, %0d failed, %0d ignored",
             beats_in, beats_out, done_seen, failed_seen, ignored_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
